/* src/cfnns_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cfnns_pkg;

    localparam int OPC_W      = 2;
    localparam int DIM_W      = 10;
    localparam int PAN_W      = 25;
    localparam int STEP_W     = 20;
    localparam int TILE_W     = 11;
    localparam int SUB_W      = 4;
    localparam int PIX_W      = 16;
    localparam int SCR_W      = 9;
    localparam int FRAC_W     = 16;
    localparam int POS_W      = TILE_W + 1;
    localparam int PROD_W     = SCR_W + STEP_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int MAP_W      = SUM_W - FRAC_W;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 16;
    localparam int APB_DW     = 32;
    localparam int APB_AW     = 5;
    localparam int REG_IDX_W  = 3;

    localparam logic [OPC_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OPC_W-1:0] OP_READ  = 2'd1;
    localparam logic [OPC_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PAN_X        = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PAN_Y        = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_STEP         = 3'd4;

    localparam logic [STEP_W-1:0] STEP_RESET = 20'd65536;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

endpackage

`default_nettype wire

/* src/cfnns_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module cfnns_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 262144
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule

`default_nettype wire

/* src/clipped_frame_store_nn_scaler_top.sv */
// Channel   | Dir | Payload (lsb first)                                   | Accept
// ----------+-----+-------------------------------------------------------+------------------
// s_axis    | in  | tuser: opcode; tdata: tile_x, tile_y, tile_col,       | tvalid & tready
//           |     |   tile_row, pixel_in, screen_x, screen_y              |
// m_axis    | out | tuser: row_outside; tdata: pixel_out                  | tvalid & tready
// apb       | in  | 5 registers at byte address 4*i, 32-bit data          | psel&penable&pwrite
//
// One request per cycle while the output is not stalled and no clear is pending or
// sweeping; a read result passes through multiply, map, address and store-read stages.
// The store is a single-port RAM; a clear sweeps it one word per cycle,
// MAX_FRAME_WIDTH*MAX_FRAME_HEIGHT words (262144 by default), and so does reset.
// No request is taken while a clear is pending or sweeping; a stalled output holds the whole pipeline.
`timescale 1ns / 1ps
`default_nettype none

module clipped_frame_store_nn_scaler_top #(
    parameter int MAX_FRAME_WIDTH  = 512,
    parameter int MAX_FRAME_HEIGHT = 512,
    parameter int SCREEN_MAX_WIDTH = 320
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // tile_x, tile_y, tile_col, tile_row, pixel_in, screen_x, screen_y
    input  wire logic [cfnns_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // opcode
    input  wire logic [cfnns_pkg::OPC_W-1:0]        s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // pixel_out
    output logic      [cfnns_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // row_outside
    output logic      [0:0]                         m_axis_tuser,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [cfnns_pkg::APB_AW-1:0]       paddr,
    input  wire logic [cfnns_pkg::APB_DW-1:0]       pwdata,
    output logic      [cfnns_pkg::APB_DW-1:0]       prdata,
    output logic                                    pready
);

    import cfnns_pkg::*;

    localparam int DEPTH = MAX_FRAME_WIDTH * MAX_FRAME_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = $clog2(MAX_FRAME_WIDTH + 1);
    localparam int EH    = $clog2(MAX_FRAME_HEIGHT + 1);
    localparam int CFW   = (EW > DIM_W) ? EW : DIM_W;
    localparam int CFH   = (EH > DIM_W) ? EH : DIM_W;
    localparam int RW    = $clog2(MAX_FRAME_HEIGHT);
    localparam int CLW   = $clog2(MAX_FRAME_WIDTH);
    localparam int CMPW  = (MAP_W > EW) ? ((MAP_W > EH) ? MAP_W : EH)
                                        : ((EW > EH) ? EW : EH);
    localparam int SXW0  = $clog2(SCREEN_MAX_WIDTH + 1);
    localparam int SXW   = (SXW0 > SCR_W) ? SXW0 : SCR_W;
    localparam int PW    = RW + EW;

    // configuration
    logic [DIM_W-1:0]  r_frame_width;
    logic [DIM_W-1:0]  r_frame_height;
    logic [PAN_W-1:0]  r_pan_x;
    logic [PAN_W-1:0]  r_pan_y;
    logic [STEP_W-1:0] r_step;
    logic              cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;
    logic [EW-1:0]     eff_w;
    logic [EH-1:0]     eff_h;

    // control
    t_state            r_state;
    t_state            n_state;
    logic [AW-1:0]     r_sweep;
    logic [AW-1:0]     n_sweep;
    logic              r_clr_pend;
    logic              adv;
    logic              in_acc;
    logic              sweep_last;

    // input fields
    logic [OPC_W-1:0]  in_op;
    logic [TILE_W-1:0] in_tx;
    logic [TILE_W-1:0] in_ty;
    logic [SUB_W-1:0]  in_tc;
    logic [SUB_W-1:0]  in_tr;
    logic [PIX_W-1:0]  in_pix;
    logic [SCR_W-1:0]  in_sx;
    logic [SCR_W-1:0]  in_sy;

    // stage B: tile position and scale products
    logic              r_b_vld;
    logic [OPC_W-1:0]  r_b_op;
    logic [POS_W-1:0]  r_b_dx;
    logic [POS_W-1:0]  r_b_dy;
    logic [PROD_W-1:0] r_b_px;
    logic [PROD_W-1:0] r_b_py;
    logic              r_b_sx_ok;
    logic [PIX_W-1:0]  r_b_pix;

    // stage C: mapped position and clipping
    logic              r_c_vld;
    logic [OPC_W-1:0]  r_c_op;
    logic              r_c_hit;
    logic              r_c_rowout;
    logic [RW-1:0]     r_c_row;
    logic [CLW-1:0]    r_c_col;
    logic [PIX_W-1:0]  r_c_pix;
    logic [SUM_W-1:0]  sum_x;
    logic [SUM_W-1:0]  sum_y;
    logic [MAP_W-1:0]  map_x;
    logic [MAP_W-1:0]  map_y;
    logic              rd_rowout;
    logic              rd_hit;
    logic              wr_hit;

    // stage D: store address, memory access
    logic              r_d_vld;
    logic [OPC_W-1:0]  r_d_op;
    logic              r_d_hit;
    logic              r_d_rowout;
    logic [AW-1:0]     r_d_addr;
    logic [PIX_W-1:0]  r_d_pix;
    logic [PW-1:0]     row_base;

    // stage F: read data
    logic              r_f_vld;
    logic              r_f_hit;
    logic              r_f_rowout;

    // output register
    logic              r_out_vld;
    logic [PIX_W-1:0]  r_out_pix;
    logic              r_out_row;

    // ram port
    logic              ram_we;
    logic              ram_re;
    logic [AW-1:0]     ram_addr;
    logic [PIX_W-1:0]  ram_wdata;
    logic [PIX_W-1:0]  ram_rdata;

    assign in_op  = s_axis_tuser;
    assign in_tx  = s_axis_tdata[10:0];
    assign in_ty  = s_axis_tdata[21:11];
    assign in_tc  = s_axis_tdata[25:22];
    assign in_tr  = s_axis_tdata[29:26];
    assign in_pix = s_axis_tdata[45:30];
    assign in_sx  = s_axis_tdata[54:46];
    assign in_sy  = s_axis_tdata[63:55];

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[APB_AW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= DIM_W'(1);
            r_frame_height <= DIM_W'(1);
            r_pan_x        <= '0;
            r_pan_y        <= '0;
            r_step         <= STEP_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[DIM_W-1:0];
                REG_PAN_X:        r_pan_x        <= pwdata[PAN_W-1:0];
                REG_PAN_Y:        r_pan_y        <= pwdata[PAN_W-1:0];
                REG_STEP:         r_step         <= pwdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_FRAME_WIDTH:  prdata = APB_DW'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DW'(r_frame_height);
            REG_PAN_X:        prdata = APB_DW'(r_pan_x);
            REG_PAN_Y:        prdata = APB_DW'(r_pan_y);
            REG_STEP:         prdata = APB_DW'(r_step);
            default:          prdata = '0;
        endcase
    end

    // clamp frame size to the store
    assign eff_w = (CFW'(r_frame_width) > CFW'(MAX_FRAME_WIDTH))
                 ? EW'(MAX_FRAME_WIDTH) : EW'(r_frame_width);
    assign eff_h = (CFH'(r_frame_height) > CFH'(MAX_FRAME_HEIGHT))
                 ? EH'(MAX_FRAME_HEIGHT) : EH'(r_frame_height);

    // handshake
    assign adv           = !r_out_vld || m_axis_tready;
    assign s_axis_tready = adv && (r_state == ST_RUN) && !r_clr_pend;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign sweep_last    = (r_sweep == AW'(DEPTH - 1));

    // state machine: next state
    always_comb begin
        n_state = r_state;
        n_sweep = r_sweep;
        case (r_state)
            ST_CLEAR: begin
                n_sweep = r_sweep + AW'(1);
                if (sweep_last) begin
                    n_state = ST_RUN;
                    n_sweep = '0;
                end
            end
            ST_RUN: begin
                if (adv && r_d_vld && (r_d_op == OP_CLEAR)) begin
                    n_state = ST_CLEAR;
                end
            end
            default: begin
                n_state = ST_CLEAR;
                n_sweep = '0;
            end
        endcase
    end

    // state machine: store port
    always_comb begin
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_re    = 1'b0;
                ram_addr  = r_sweep;
                ram_wdata = '0;
            end
            ST_RUN: begin
                ram_we    = adv && r_d_vld && r_d_hit && (r_d_op == OP_WRITE);
                ram_re    = adv && r_d_vld && r_d_hit && (r_d_op == OP_READ);
                ram_addr  = r_d_addr;
                ram_wdata = r_d_pix;
            end
            default: begin
                ram_we    = 1'b0;
                ram_re    = 1'b0;
                ram_addr  = r_d_addr;
                ram_wdata = r_d_pix;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_sweep    <= '0;
            r_clr_pend <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sweep <= n_sweep;
            if (in_acc && (in_op == OP_CLEAR)) begin
                r_clr_pend <= 1'b1;
            end else if ((r_state == ST_CLEAR) && sweep_last) begin
                r_clr_pend <= 1'b0;
            end
        end
    end

    // stage C logic
    assign sum_y     = SUM_W'(r_pan_y) + SUM_W'(r_b_py);
    assign sum_x     = SUM_W'(r_pan_x) + SUM_W'(r_b_px);
    assign map_y     = sum_y[SUM_W-1:FRAC_W];
    assign map_x     = sum_x[SUM_W-1:FRAC_W];
    assign rd_rowout = CMPW'(map_y) >= CMPW'(eff_h);
    assign rd_hit    = !rd_rowout && (CMPW'(map_x) < CMPW'(eff_w)) && r_b_sx_ok;
    assign wr_hit    = !r_b_dx[POS_W-1] && !r_b_dy[POS_W-1]
                    && (CMPW'(r_b_dx[POS_W-2:0]) < CMPW'(eff_w))
                    && (CMPW'(r_b_dy[POS_W-2:0]) < CMPW'(eff_h));

    // stage D logic
    assign row_base = PW'(r_c_row) * PW'(eff_w);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_d_vld   <= 1'b0;
            r_f_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_b_vld   <= in_acc;
            r_c_vld   <= r_b_vld;
            r_d_vld   <= r_c_vld;
            r_f_vld   <= r_d_vld && (r_d_op == OP_READ);
            r_out_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_op    <= in_op;
            r_b_dx    <= {in_tx[TILE_W-1], in_tx} + POS_W'(in_tc);
            r_b_dy    <= {in_ty[TILE_W-1], in_ty} + POS_W'(in_tr);
            r_b_px    <= PROD_W'(in_sx) * PROD_W'(r_step);
            r_b_py    <= PROD_W'(in_sy) * PROD_W'(r_step);
            r_b_sx_ok <= SXW'(in_sx) < SXW'(SCREEN_MAX_WIDTH);
            r_b_pix   <= in_pix;

            r_c_op     <= r_b_op;
            r_c_pix    <= r_b_pix;
            r_c_rowout <= rd_rowout;
            if (r_b_op == OP_WRITE) begin
                r_c_hit <= wr_hit;
                r_c_row <= r_b_dy[RW-1:0];
                r_c_col <= r_b_dx[CLW-1:0];
            end else begin
                r_c_hit <= rd_hit;
                r_c_row <= map_y[RW-1:0];
                r_c_col <= map_x[CLW-1:0];
            end

            r_d_op     <= r_c_op;
            r_d_hit    <= r_c_hit;
            r_d_rowout <= r_c_rowout;
            r_d_pix    <= r_c_pix;
            r_d_addr   <= AW'(row_base) + AW'(r_c_col);

            r_f_hit    <= r_d_hit;
            r_f_rowout <= r_d_rowout;

            r_out_pix  <= r_f_hit ? ram_rdata : '0;
            r_out_row  <= r_f_rowout;
        end
    end

    cfnns_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign m_axis_tvalid   = r_out_vld;
    assign m_axis_tdata    = r_out_pix;
    assign m_axis_tuser[0] = r_out_row;

`ifndef SYNTHESIS
    a_no_access_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !(r_d_vld && ((r_d_op == OP_READ) || (r_d_op == OP_WRITE))))
        else $error("store request in flight during sweep");

    a_one_clear_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({r_b_vld && (r_b_op == OP_CLEAR), r_c_vld && (r_c_op == OP_CLEAR),
                    r_d_vld && (r_d_op == OP_CLEAR)}) <= 1)
        else $error("more than one clear in pipeline");

    a_row_out_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("pixel returned for row outside frame");

    a_sweep_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_CLEAR) && sweep_last) |=> ((r_state == ST_RUN) && !r_clr_pend))
        else $error("sweep did not end");
`endif

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import cfnns_pkg::*;

    localparam int MAX_W         = 512;
    localparam int MAX_H         = 512;
    localparam int SCREEN_W      = 320;
    localparam int STORE_DEPTH   = MAX_W * MAX_H;
    localparam int PHASE_COUNT   = 9;
    localparam int PHASE_ITEMS   = 200;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 3_000_000;

    localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             row_outside;
    } t_pixel_result;

    class t_scaler_scoreboard;
        bit   [PIX_W-1:0]  frame_store [STORE_DEPTH];
        logic [DIM_W-1:0]  frame_width;
        logic [DIM_W-1:0]  frame_height;
        logic [PAN_W-1:0]  pan_x;
        logic [PAN_W-1:0]  pan_y;
        logic [STEP_W-1:0] step;
        t_pixel_result     pending [$];
        int                errors;
        int                reads_checked;
        int                requests_seen;

        function new();
            frame_width  = 1;
            frame_height = 1;
            pan_x        = '0;
            pan_y        = '0;
            step         = STEP_RESET;
            clear_store();
        endfunction

        function void clear_store();
            foreach (frame_store[i]) frame_store[i] = '0;
        endfunction

        function int width_eff();
            return (frame_width > MAX_W) ? MAX_W : int'(frame_width);
        endfunction

        function int height_eff();
            return (frame_height > MAX_H) ? MAX_H : int'(frame_height);
        endfunction

        function void set_register(logic [REG_IDX_W-1:0] idx, logic [APB_DW-1:0] value);
            case (idx)
                REG_FRAME_WIDTH:  frame_width  = value[DIM_W-1:0];
                REG_FRAME_HEIGHT: frame_height = value[DIM_W-1:0];
                REG_PAN_X:        pan_x        = value[PAN_W-1:0];
                REG_PAN_Y:        pan_y        = value[PAN_W-1:0];
                REG_STEP:         step         = value[STEP_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_request(logic [OPC_W-1:0] op, logic [IN_DATA_W-1:0] data);
            logic signed [TILE_W-1:0] tile_x;
            logic signed [TILE_W-1:0] tile_y;
            logic [SUB_W-1:0]         col;
            logic [SUB_W-1:0]         row;
            logic [PIX_W-1:0]         pix;
            logic [SCR_W-1:0]         sx;
            logic [SCR_W-1:0]         sy;
            int                       dx;
            int                       dy;
            int                       w;
            int                       h;
            longint unsigned          mx;
            longint unsigned          my;
            t_pixel_result            res;
            tile_x = data[10:0];
            tile_y = data[21:11];
            col    = data[25:22];
            row    = data[29:26];
            pix    = data[45:30];
            sx     = data[54:46];
            sy     = data[63:55];
            w      = width_eff();
            h      = height_eff();
            requests_seen++;
            case (op)
                OP_CLEAR: clear_store();
                OP_WRITE: begin
                    dx = int'(tile_x) + int'(col);
                    dy = int'(tile_y) + int'(row);
                    if (dx >= 0 && dy >= 0 && dx < w && dy < h) begin
                        frame_store[dy * w + dx] = pix;
                    end
                end
                OP_READ: begin
                    my = (64'(pan_y) + 64'(sy) * 64'(step)) >> FRAC_W;
                    mx = (64'(pan_x) + 64'(sx) * 64'(step)) >> FRAC_W;
                    res.row_outside = (my >= h);
                    res.pixel       = '0;
                    if (!res.row_outside && mx < w && sx < SCREEN_W) begin
                        res.pixel = frame_store[my * w + mx];
                    end
                    pending.insert(pending.size(), res);
                end
                default: ;
            endcase
        endfunction

        function void note_error(string msg);
            errors++;
            if (errors <= 10) $display("mismatch: %s", msg);
        endfunction

        function void check_result(logic [PIX_W-1:0] pixel, logic row_outside);
            t_pixel_result exp_res;
            if (pending.size() == 0) begin
                note_error($sformatf("result with nothing pending: pixel=%h row_outside=%b",
                                     pixel, row_outside));
                return;
            end
            exp_res = pending.pop_front();
            reads_checked++;
            if (pixel !== exp_res.pixel) begin
                note_error($sformatf("read %0d pixel: expected %h, got %h",
                                     reads_checked, exp_res.pixel, pixel));
            end
            if (row_outside !== exp_res.row_outside) begin
                note_error($sformatf("read %0d row_outside: expected %b, got %b",
                                     reads_checked, exp_res.row_outside, row_outside));
            end
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [OPC_W-1:0]      s_axis_tuser  = OP_WRITE;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_AW-1:0]     paddr         = '0;
    logic [APB_DW-1:0]     pwdata        = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    t_scaler_scoreboard sb = new();

    int sender_idle     = 37;
    int receiver_idle   = 84;
    int hold_asked      = 0;
    int hold_done       = 0;
    int hold_left       = 0;
    int cycle_count     = 0;
    int register_writes = 0;

    clipped_frame_store_nn_scaler_top #(
        .MAX_FRAME_WIDTH  (MAX_W),
        .MAX_FRAME_HEIGHT (MAX_H),
        .SCREEN_MAX_WIDTH (SCREEN_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, sb.pending.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (hold_asked != hold_done) begin
            hold_done = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= receiver_idle);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata, m_axis_tuser[0]);
        end
    end

    function automatic logic [IN_DATA_W-1:0] pack_request(int tx, int ty, int col, int row,
                                                          int pix, int sx, int sy);
        return {SCR_W'(sy), SCR_W'(sx), PIX_W'(pix), SUB_W'(row), SUB_W'(col),
                TILE_W'(ty), TILE_W'(tx)};
    endfunction

    // Highest screen coordinate whose mapped position stays inside the frame.
    function automatic int axis_limit(logic [PAN_W-1:0] pan, int extent, int top);
        longint unsigned span;
        if (sb.step == 0) return top;
        span = 64'(extent) << FRAC_W;
        if (span <= 64'(pan)) return top;
        span = (span - 1 - 64'(pan)) / 64'(sb.step);
        return (span < 64'(top)) ? int'(span) : top;
    endfunction

    task automatic send_request(logic [OPC_W-1:0] op, logic [IN_DATA_W-1:0] data);
        while ($urandom_range(0, 99) < sender_idle) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(op, data);
        @(negedge i_clk);
    endtask

    task automatic write_pixel(int tx, int ty, int col, int row, int pix);
        send_request(OP_WRITE, pack_request(tx, ty, col, row, pix, 0, 0));
    endtask

    task automatic read_pixel(int sx, int sy);
        send_request(OP_READ, pack_request(0, 0, 0, 0, 0, sx, sy));
    endtask

    // Drain all results, let in-flight writes and any sweep finish.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_register(idx, value);
        register_writes++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic configure(int w, int h, int px, int py, int st);
        apb_write(REG_FRAME_WIDTH, w);
        apb_write(REG_FRAME_HEIGHT, h);
        apb_write(REG_PAN_X, px);
        apb_write(REG_PAN_Y, py);
        apb_write(REG_STEP, st);
    endtask

    task automatic random_request(output bit counted);
        int w;
        int h;
        int col;
        int row;
        int roll;
        w       = sb.width_eff();
        h       = sb.height_eff();
        roll    = $urandom_range(0, 99);
        counted = 1'b1;
        if (roll < 45 && w > 0 && h > 0) begin
            col = $urandom_range(0, 15);
            row = $urandom_range(0, 15);
            send_request(OP_WRITE, pack_request($urandom_range(0, w - 1) - col,
                                                $urandom_range(0, h - 1) - row, col, row,
                                                $urandom_range(0, 16'hFFFF),
                                                $urandom_range(0, 511),
                                                $urandom_range(0, 511)));
        end else if (roll < 85) begin
            send_request(OP_READ, pack_request($urandom_range(0, 2047), $urandom_range(0, 2047),
                                               $urandom_range(0, 15), $urandom_range(0, 15),
                                               $urandom_range(0, 16'hFFFF),
                                               $urandom_range(0, axis_limit(sb.pan_x, w,
                                                                            SCREEN_W - 1)),
                                               $urandom_range(0, axis_limit(sb.pan_y, h,
                                                                            511))));
        end else if (roll < 95) begin
            send_request(($urandom_range(0, 1) != 0) ? OP_READ : OP_WRITE,
                         {$urandom, $urandom});
        end else begin
            send_request(OP_UNUSED, {$urandom, $urandom});
            counted = 1'b0;
        end
    endtask

    task automatic random_phase(int idx);
        case (idx)
            0: configure(32, 32, 0, 0, 65536);
            1: configure($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(0, 8 << 16),
                         $urandom_range(0, 8 << 16), $urandom_range(16384, 131072));
            2: configure(1023, 1023, 0, 0, 32768);
            3: configure(1, 1, 0, 0, 0);
            4: configure(512, 512, $urandom_range(0, 1 << 16), $urandom_range(0, 1 << 16),
                         20'hFFFFF);
            5: configure($urandom_range(1, 40), $urandom_range(1, 40),
                         $urandom_range(0, 25'h1FFFFFF), $urandom_range(0, 25'h1FFFFFF),
                         $urandom_range(0, 20'hFFFFF));
            6: configure(0, 16, 0, 0, 65536);
            7: configure($urandom_range(1, 100), $urandom_range(1, 100),
                         $urandom_range(0, 4 << 16), $urandom_range(0, 4 << 16),
                         $urandom_range(8192, 98304));
            default: configure(400, 8, 0, 0, 65536);
        endcase
    endtask

    initial begin
        int  done;
        bit  counted;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        wait_drained();

        configure(16, 16, 0, 0, 65536);
        write_pixel(0, 0, 0, 0, 16'hFFFF);
        write_pixel(-1024, -1024, 15, 15, 16'h1111);
        write_pixel(1023, 1023, 15, 15, 16'h2222);
        write_pixel(-1, -1, 1, 1, 16'h1234);
        write_pixel(0, 0, 15, 15, 16'hA5A5);
        write_pixel(-16, 0, 15, 0, 16'h3333);
        write_pixel(15, 0, 1, 0, 16'h4444);
        read_pixel(0, 0);
        read_pixel(15, 15);
        read_pixel(16, 0);
        read_pixel(0, 16);
        read_pixel(511, 511);
        send_request(OP_UNUSED, pack_request(0, 0, 0, 0, 16'h5555, 0, 0));
        send_request(OP_CLEAR, '0);
        read_pixel(15, 15);
        wait_drained();

        configure(0, 0, 0, 0, 65536);
        write_pixel(0, 0, 0, 0, 16'h6666);
        read_pixel(0, 0);
        wait_drained();

        configure(1023, 1023, 0, 0, 65536);
        write_pixel(320, 0, 0, 0, 16'hBEEF);
        write_pixel(319, 0, 0, 0, 16'hCAFE);
        read_pixel(320, 0);
        read_pixel(319, 0);
        wait_drained();

        configure(1023, 1023, 25'h1FFFFFF, 25'h1FFFFFF, 20'hFFFFF);
        read_pixel(319, 511);
        wait_drained();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            sender_idle   = (p < 3) ? 37 : (p < 6) ? 84 : 0;
            receiver_idle = (p < 3) ? 84 : (p < 6) ? 37 : 0;
            random_phase(p);
            if (p == 6) hold_asked++;
            done = 0;
            while (done < PHASE_ITEMS) begin
                if (p == 7 && done == PHASE_ITEMS / 2) wait_drained();
                random_request(counted);
                if (counted) done++;
            end
            wait_drained();
        end

        $display("%0d requests sent over %0d register writes, %0d read results compared",
                 sb.requests_seen, register_writes, sb.reads_checked);
        $display("settings covered zero, minimum, oversized and wide frames, full pan and step");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d results never arrived", sb.errors, sb.pending.size());
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
